// ----- design/sdau_pkg.sv -----
// sdau_pkg: shared constants and types for the signed binary to decimal ascii unit
// no dependencies; used by the interfaces, the bcd cell and the top level
`default_nettype none

package sdau_pkg;

    localparam int ValueWidth = 64;
    localparam int CharWidth  = 6;
    localparam int DigitWidth = 4;
    localparam int NumCells   = 19;
    localparam int Radix      = 10;

    localparam logic [CharWidth-1:0] DigitBase = CharWidth'(48);
    localparam logic [CharWidth-1:0] MinusCode = CharWidth'(45);

    // shift-add-3 correction: a digit at or above half the radix would overflow on doubling
    localparam logic [DigitWidth-1:0] DabbleThresh = DigitWidth'(Radix / 2);
    localparam logic [DigitWidth-1:0] DabbleAdd    =
        DigitWidth'((2 ** (DigitWidth - 1)) - (Radix / 2));

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_SHIFT
    } t_cell_op;

endpackage

`default_nettype wire

// ----- design/sdau_if.sv -----
// sdau_if: valid/ready channel interfaces for the value input and the character output
// depends on sdau_pkg for field widths
`default_nettype none

interface sdau_value_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sdau_pkg::ValueWidth-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sdau_char_if;
    logic                             valid;
    logic                             ready;
    logic [sdau_pkg::CharWidth-1:0]   char_code;
    logic                             last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// ----- design/sdau_bcd_cell.sv -----
// sdau_bcd_cell: one decimal digit of the conversion row (shift-add-3 step, digit shift, clear or hold)
// depends on sdau_pkg for the digit width, correction constants and cell operation codes
`default_nettype none

module sdau_bcd_cell (
    input  wire logic                            i_clk,
    input  var  sdau_pkg::t_cell_op              i_op,
    input  wire logic                            i_bit,
    input  wire logic [sdau_pkg::DigitWidth-1:0] i_digit,
    output logic                                 o_bit,
    output logic [sdau_pkg::DigitWidth-1:0]      o_digit
);
    import sdau_pkg::*;

    logic [DigitWidth-1:0] r_digit;
    logic [DigitWidth-1:0] n_digit;
    logic [DigitWidth-1:0] w_adj;

    always_comb begin
        w_adj = (r_digit >= DabbleThresh) ? DigitWidth'(r_digit + DabbleAdd) : r_digit;
        case (i_op)
            CELL_CLEAR:  n_digit = '0;
            CELL_DABBLE: n_digit = {w_adj[DigitWidth-2:0], i_bit};
            CELL_SHIFT:  n_digit = i_digit;
            default:     n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    // carry into the next more significant digit
    assign o_bit   = w_adj[DigitWidth-1];
    assign o_digit = r_digit;

endmodule

`default_nettype wire

// ----- design/signed_binary_to_decimal_ascii_unit.sv -----
// sequence: accept, then shift the magnitude through the bcd cell row, then emit the sign first
// when negative, drop leading zeros, hand over to emission and emit the digits one per cycle
// while the sink does not stall
// throughput: one value at a time; sink stalls add their length; the next value is taken once
// the last character sits in the output register
// reset: synchronous active low, clears state machine and output valid; cells cleared per value
`default_nettype none

module signed_binary_to_decimal_ascii_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sdau_value_if.sink         i_value,
    sdau_char_if.source        o_char
);
    import sdau_pkg::*;

    localparam int BitCntWidth = $clog2(ValueWidth);
    localparam int DigCntWidth = $clog2(NumCells + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [ValueWidth-1:0]   r_mag;
    logic                    r_neg;
    logic [BitCntWidth-1:0]  r_bit_cnt;
    logic [DigCntWidth-1:0]  r_dig_left;
    logic                    r_out_valid;
    logic [CharWidth-1:0]    r_out_char;
    logic                    r_out_last;

    logic                    w_in_fire;
    logic                    w_slot;
    logic                    w_emit;
    logic                    w_skip;
    logic                    w_last_dig;
    t_cell_op                w_op;
    logic [ValueWidth-1:0]   w_vbits;
    logic [DigitWidth-1:0]   w_top;
    logic [NumCells:0]       w_bit;
    logic [DigitWidth-1:0]   w_digit [NumCells];

    assign w_vbits    = $unsigned(i_value.value);
    assign w_in_fire  = i_value.valid && i_value.ready;
    assign w_slot     = !r_out_valid || o_char.ready;
    assign w_emit     = w_slot && ((r_state == S_SIGN) || (r_state == S_EMIT));
    assign w_top      = w_digit[NumCells-1];
    assign w_last_dig = (r_dig_left == DigCntWidth'(1));
    assign w_skip     = (w_top == '0) && !w_last_dig;

    assign i_value.ready  = (r_state == S_IDLE);
    assign o_char.valid     = r_out_valid;
    assign o_char.char_code = r_out_char;
    assign o_char.last_char = r_out_last;

    always_comb begin
        unique case (r_state)
            S_IDLE:  w_op = w_in_fire ? CELL_CLEAR : CELL_HOLD;
            S_CONV:  w_op = CELL_DABBLE;
            S_SKIP:  w_op = w_skip ? CELL_SHIFT : CELL_HOLD;
            S_EMIT:  w_op = w_slot ? CELL_SHIFT : CELL_HOLD;
            default: w_op = CELL_HOLD;
        endcase
    end

    // magnitude enters the least significant cell msb first
    assign w_bit[0] = r_mag[ValueWidth-1];

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        logic [DigitWidth-1:0] w_lower;

        if (g == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_rest
            assign w_lower = w_digit[g-1];
        end

        sdau_bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_bit   (w_bit[g]),
            .i_digit (w_lower),
            .o_bit   (w_bit[g+1]),
            .o_digit (w_digit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_char.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_neg     <= w_vbits[ValueWidth-1];
                        r_mag     <= w_vbits[ValueWidth-1] ? (~w_vbits + 1'b1) : w_vbits;
                        r_bit_cnt <= BitCntWidth'(ValueWidth - 1);
                        r_state   <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_mag <= {r_mag[ValueWidth-2:0], 1'b0};
                    if (r_bit_cnt == '0) begin
                        r_dig_left <= DigCntWidth'(NumCells);
                        r_state    <= r_neg ? S_SIGN : S_SKIP;
                    end else begin
                        r_bit_cnt <= r_bit_cnt - 1'b1;
                    end
                end
                S_SIGN: begin
                    if (w_slot) begin
                        r_out_char  <= MinusCode;
                        r_out_last  <= 1'b0;
                        r_state     <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    // drop leading zeros, keeping at least one digit
                    if (w_skip) begin
                        r_dig_left <= r_dig_left - 1'b1;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot) begin
                        r_out_char  <= CharWidth'(DigitBase + CharWidth'(w_top));
                        r_out_last  <= w_last_dig;
                        r_dig_left  <= r_dig_left - 1'b1;
                        if (w_last_dig) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
